// ===== rtl/st_pkg.sv =====
// Shared types, constants and keyword tables for the source tokenizer.
`default_nettype none

package st_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_STRING = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TYPE     = 3'd0,
        KIND_KEYWORD  = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_NUMBER   = 3'd3,
        KIND_SYMBOL   = 3'd4,
        KIND_OPERATOR = 3'd5,
        KIND_STRING   = 3'd6,
        KIND_EOF      = 3'd7
    } t_kind;

    localparam logic [7:0] CHAR_QUOTE      = 8'h22;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;

    localparam int NUM_CAND = 4;
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [7:0]  first;
        logic        last;
    } t_token;

    // Up to three tokens produced by one source transaction, in order.
    typedef struct packed {
        logic [1:0]   count;
        t_token [2:0] tok;
    } t_batch;

    // Candidate words: 0 class, 1 void, 2 int, 3 string.
    function automatic logic [2:0] cand_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0: len = 3'd5;
            2'd1: len = 3'd4;
            2'd2: len = 3'd3;
            default: len = 3'd6;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0: begin
                case (idx)
                    3'd0: ch = "c";
                    3'd1: ch = "l";
                    3'd2: ch = "a";
                    3'd3: ch = "s";
                    3'd4: ch = "s";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0: ch = "v";
                    3'd1: ch = "o";
                    3'd2: ch = "i";
                    3'd3: ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    3'd0: ch = "i";
                    3'd1: ch = "n";
                    3'd2: ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0: ch = "s";
                    3'd1: ch = "t";
                    3'd2: ch = "r";
                    3'd3: ch = "i";
                    3'd4: ch = "n";
                    3'd5: ch = "g";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/st_ifs.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface st_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_source;

    modport source (output valid, has_byte, data_byte, end_of_source, input ready);
    modport sink   (input valid, has_byte, data_byte, end_of_source, output ready);
endinterface

interface st_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic        last_of_run;

    modport source (output valid, token_kind, token_start, token_length, first_char,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, first_char,
                    last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/source_tokenizer_core.sv =====
// Top level of the streaming source tokenizer.
// A token is offered from the result register once its transaction has left the input
// register. Throughput: one source transaction per cycle while each yields at most one
// token and the sink does not stall; a transaction with more than one token holds the
// three-slot result register until its last token is taken. Reset (synchronous, active
// low) returns the scanner to idle at offset zero and drops any queued tokens.
`default_nettype none

module source_tokenizer_core #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    st_in_if.sink     i_in,
    st_out_if.source  o_out
);
    import st_pkg::*;

    t_batch w_batch;
    logic   w_push;
    logic   w_load_ok;

    st_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_load_ok (w_load_ok),
        .o_batch   (w_batch),
        .o_push    (w_push)
    );

    st_resbuf u_resbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_batch   (w_batch),
        .i_push    (w_push),
        .o_load_ok (w_load_ok),
        .o_out     (o_out)
    );

    // An end of file token always closes the run of its transaction.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.token_kind == KIND_EOF |-> o_out.last_of_run)
        else $error("end of file token without last_of_run");

    // End of file carries no length and no first byte.
    a_eof_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.token_kind == KIND_EOF |->
        o_out.token_length == 16'd0 && o_out.first_char == 8'h00)
        else $error("end of file token with nonzero length or first byte");

    // A loaded batch with tokens is offered on the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_batch.count != 2'd0 |=> o_out.valid)
        else $error("loaded tokens not offered");

endmodule

`default_nettype wire

// ===== rtl/st_scan.sv =====
// Input register, scanner state and the single-pass token step.
`default_nettype none

module st_scan #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    st_in_if.sink              i_in,
    input  wire logic          i_load_ok,
    output st_pkg::t_batch     o_batch,
    output logic               o_push
);
    import st_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LENGTH_BITS;

    // Input register.
    logic       r_in_valid, n_in_valid;
    logic       r_has, r_eos;
    logic [7:0] r_byte;

    // Scanner state.
    t_mode          r_mode, n_mode;
    logic [OB-1:0]  r_off, n_off;
    logic [OB-1:0]  r_ost, n_ost;
    logic [LB-1:0]  r_olen, n_olen;
    logic [7:0]     r_ofirst, n_ofirst;
    logic [3:0]     r_wm, n_wm;

    logic   w_fire;
    t_batch w_batch;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] len);
        return (len == {LB{1'b1}}) ? len : len + LB'(1);
    endfunction

    // Keeps a candidate bit only while the word so far is a prefix of it.
    function automatic logic [3:0] match_next(input logic [3:0] wm, input logic [LB-1:0] len,
                                              input logic [7:0] c);
        logic [3:0] res;
        res = wm;
        for (int k = 0; k < NUM_CAND; k++) begin
            if (64'(len) >= 64'(cand_len(2'(k)))) begin
                res[k] = 1'b0;
            end else if (cand_char(2'(k), len[2:0]) != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic t_kind close_kind(input t_mode mode, input logic [3:0] wm,
                                         input logic [LB-1:0] len);
        t_kind kind;
        kind = KIND_IDENT;
        case (mode)
            MODE_WORD: begin
                for (int k = 0; k < NUM_CAND; k++) begin
                    if (wm[k] && 64'(len) == 64'(cand_len(2'(k)))) begin
                        kind = (k >= 2) ? KIND_TYPE : KIND_KEYWORD;
                    end
                end
            end
            MODE_NUMBER: kind = KIND_NUMBER;
            MODE_STRING: kind = KIND_STRING;
            default:     kind = KIND_IDENT;
        endcase
        return kind;
    endfunction

    function automatic t_token mk_token(input t_kind kind, input logic [OB-1:0] start,
                                        input logic [LB-1:0] len, input logic [7:0] first);
        t_token t;
        logic [63:0] s64;
        logic [63:0] l64;
        s64 = 64'(start);
        l64 = 64'(len);
        t.kind   = kind;
        t.start  = s64[31:0];
        t.length = l64[15:0];
        t.first  = first;
        t.last   = 1'b0;
        return t;
    endfunction

    assign w_fire     = r_in_valid && i_load_ok;
    assign i_in.ready = !r_in_valid || w_fire;
    assign n_in_valid = i_in.valid ? 1'b1 : (w_fire ? 1'b0 : r_in_valid);

    always_comb begin
        t_mode         mode1;
        logic [OB-1:0] off1, ost1;
        logic [LB-1:0] olen1;
        logic [7:0]    ofirst1;
        logic [3:0]    wm1;
        logic          idle_path;
        t_token        tk [4];
        logic [3:0]    tv;
        logic [2:0]    idx;

        mode1     = r_mode;
        off1      = r_off;
        ost1      = r_ost;
        olen1     = r_olen;
        ofirst1   = r_ofirst;
        wm1       = r_wm;
        idle_path = 1'b0;
        tv        = 4'b0000;
        for (int i = 0; i < 4; i++) begin
            tk[i] = '0;
        end

        if (r_has) begin
            case (r_mode)
                MODE_STRING: begin
                    if (r_byte == CHAR_QUOTE) begin
                        tv[0] = 1'b1;
                        tk[0] = mk_token(KIND_STRING, r_ost, r_olen, r_ofirst);
                        mode1 = MODE_IDLE;
                    end else begin
                        if (r_olen == '0) begin
                            ofirst1 = r_byte;
                        end
                        olen1 = sat_inc(r_olen);
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(r_byte) || is_digit(r_byte) || r_byte == CHAR_UNDERSCORE) begin
                        wm1   = match_next(r_wm, r_olen, r_byte);
                        olen1 = sat_inc(r_olen);
                    end else begin
                        tv[0] = 1'b1;
                        tk[0] = mk_token(close_kind(MODE_WORD, r_wm, r_olen), r_ost, r_olen,
                                         r_ofirst);
                        mode1     = MODE_IDLE;
                        idle_path = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(r_byte)) begin
                        olen1 = sat_inc(r_olen);
                    end else begin
                        tv[0]     = 1'b1;
                        tk[0]     = mk_token(KIND_NUMBER, r_ost, r_olen, r_ofirst);
                        mode1     = MODE_IDLE;
                        idle_path = 1'b1;
                    end
                end
                default: idle_path = 1'b1;
            endcase

            // The byte that ends a word or number is then taken as from idle.
            if (idle_path) begin
                if (is_space(r_byte)) begin
                    mode1 = MODE_IDLE;
                end else if (is_alpha(r_byte) || r_byte == CHAR_UNDERSCORE) begin
                    mode1   = MODE_WORD;
                    ost1    = r_off;
                    ofirst1 = r_byte;
                    olen1   = LB'(1);
                    wm1     = match_next(4'hF, '0, r_byte);
                end else if (is_digit(r_byte)) begin
                    mode1   = MODE_NUMBER;
                    ost1    = r_off;
                    ofirst1 = r_byte;
                    olen1   = LB'(1);
                    wm1     = 4'hF;
                end else if (r_byte == CHAR_QUOTE) begin
                    mode1   = MODE_STRING;
                    ost1    = r_off + OB'(1);
                    ofirst1 = 8'h00;
                    olen1   = '0;
                    wm1     = 4'hF;
                end else if (r_byte == CHAR_EQUAL || r_byte == CHAR_PLUS ||
                             r_byte == CHAR_MINUS) begin
                    tv[1] = 1'b1;
                    tk[1] = mk_token(KIND_OPERATOR, r_off, LB'(1), r_byte);
                end else begin
                    tv[1] = 1'b1;
                    tk[1] = mk_token(KIND_SYMBOL, r_off, LB'(1), r_byte);
                end
            end
            off1 = r_off + OB'(1);
        end

        n_mode   = mode1;
        n_off    = off1;
        n_ost    = ost1;
        n_olen   = olen1;
        n_ofirst = ofirst1;
        n_wm     = wm1;

        if (r_eos) begin
            if (mode1 != MODE_IDLE) begin
                tv[2] = 1'b1;
                tk[2] = mk_token(close_kind(mode1, wm1, olen1), ost1, olen1, ofirst1);
            end
            tv[3] = 1'b1;
            tk[3] = mk_token(KIND_EOF, off1, '0, 8'h00);
            n_mode   = MODE_IDLE;
            n_off    = '0;
            n_ost    = '0;
            n_olen   = '0;
            n_ofirst = 8'h00;
            n_wm     = 4'hF;
        end

        // Pack the produced tokens in order; at most three are ever present.
        w_batch = '0;
        idx     = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (tv[i] && idx < 3'(MAX_RESULTS)) begin
                w_batch.tok[idx[1:0]] = tk[i];
                idx = idx + 3'd1;
            end
        end
        w_batch.count = idx[1:0];
        if (idx != 3'd0) begin
            w_batch.tok[idx[1:0] - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_off      <= '0;
            r_ost      <= '0;
            r_olen     <= '0;
            r_ofirst   <= 8'h00;
            r_wm       <= 4'hF;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_fire) begin
                r_mode   <= n_mode;
                r_off    <= n_off;
                r_ost    <= n_ost;
                r_olen   <= n_olen;
                r_ofirst <= n_ofirst;
                r_wm     <= n_wm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_has  <= i_in.has_byte;
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_source;
        end
    end

    assign o_batch = w_batch;
    assign o_push  = w_fire;

endmodule

`default_nettype wire

// ===== rtl/st_resbuf.sv =====
// Three-slot result register that hands tokens out one per cycle while the sink is ready.
`default_nettype none

module st_resbuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire st_pkg::t_batch i_batch,
    input  wire logic          i_push,
    output logic               o_load_ok,
    st_out_if.source           o_out
);
    import st_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_token     r_slot [3];
    t_token     n_slot [3];
    logic       w_pop;

    assign w_pop     = (r_cnt != 2'd0) && o_out.ready;
    // A new batch is loaded only when the slots are empty or drain empty in this cycle.
    assign o_load_ok = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);

    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        if (i_push) begin
            n_cnt = i_batch.count;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                n_slot[i] = i_batch.tok[i];
            end
        end else if (w_pop) begin
            n_cnt     = r_cnt - 2'd1;
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.token_kind   = r_slot[0].kind;
    assign o_out.token_start  = r_slot[0].start;
    assign o_out.token_length = r_slot[0].length;
    assign o_out.first_char   = r_slot[0].first;
    assign o_out.last_of_run  = r_slot[0].last;

endmodule

`default_nettype wire

// ===== tb/sv/token_stream_checker.sv =====
// Token checker: predicts the token stream from accepted source bytes and compares results.
`default_nettype none

module token_stream_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    st_in_if          i_src,
    st_out_if         i_tok,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import st_pkg::*;

    localparam int REPORT_LIMIT = 100;

    t_mode       scan_mode;
    logic [31:0] cursor;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [7:0]  tok_first;
    logic [3:0]  word_hits;
    t_token      tokens_due[$];
    t_token      batch[$];
    int          fails;
    string       cand_words[4] = '{"class", "void", "int", "string"};

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        fails = 0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_scanner();
        scan_mode = MODE_IDLE;
        cursor = '0;
        tok_start = '0;
        tok_len = '0;
        tok_first = '0;
        word_hits = 4'hF;
    endfunction

    function automatic void put_token(input t_kind k, input logic [31:0] s,
                                      input logic [15:0] l, input logic [7:0] f);
        t_token t;
        t.kind = k;
        t.start = s;
        t.length = l;
        t.first = f;
        t.last = 1'b0;
        batch.push_back(t);
    endfunction

    function automatic void open_token(input t_mode m, input logic [31:0] s,
                                       input logic [7:0] f);
        scan_mode = m;
        tok_start = s;
        tok_first = f;
        tok_len = '0;
        word_hits = 4'hF;
    endfunction

    // Lengths stick at the all-ones value instead of wrapping.
    function automatic void grow_token();
        if (tok_len != '1) begin
            tok_len = tok_len + 16'd1;
        end
    endfunction

    // A candidate drops out as soon as the word stops being a prefix of it.
    function automatic void match_word(input logic [7:0] c);
        for (int w = 0; w < 4; w++) begin
            if (tok_len >= cand_words[w].len() || cand_words[w][tok_len] != c) begin
                word_hits[w] = 1'b0;
            end
        end
    endfunction

    function automatic void close_token();
        t_kind k;
        if (scan_mode == MODE_IDLE) begin
            return;
        end
        if (scan_mode == MODE_NUMBER) begin
            k = KIND_NUMBER;
        end else if (scan_mode == MODE_STRING) begin
            k = KIND_STRING;
        end else begin
            k = KIND_IDENT;
            for (int w = 0; w < 4; w++) begin
                if (word_hits[w] && tok_len == cand_words[w].len()) begin
                    if (w >= 2) begin
                        k = KIND_TYPE;
                    end else begin
                        k = KIND_KEYWORD;
                    end
                end
            end
        end
        put_token(k, tok_start, tok_len, tok_first);
        scan_mode = MODE_IDLE;
    endfunction

    function automatic void scan_source_byte(input logic has, input logic [7:0] c,
                                             input logic eos);
        logic   taken;
        t_token t;
        taken = 1'b0;
        batch.delete();
        if (has) begin
            case (scan_mode)
                MODE_STRING: begin
                    taken = 1'b1;
                    if (c == CHAR_QUOTE) begin
                        close_token();
                    end else begin
                        if (tok_len == 0) begin
                            tok_first = c;
                        end
                        grow_token();
                    end
                end
                MODE_WORD: begin
                    if (is_letter(c) || is_numeral(c) || c == CHAR_UNDERSCORE) begin
                        match_word(c);
                        grow_token();
                        taken = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                MODE_NUMBER: begin
                    if (is_numeral(c)) begin
                        grow_token();
                        taken = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                default: begin
                end
            endcase
            // A byte that ended a word or number is scanned again from idle.
            if (!taken && !is_blank(c)) begin
                if (is_letter(c) || c == CHAR_UNDERSCORE) begin
                    open_token(MODE_WORD, cursor, c);
                    match_word(c);
                    grow_token();
                end else if (is_numeral(c)) begin
                    open_token(MODE_NUMBER, cursor, c);
                    grow_token();
                end else if (c == CHAR_QUOTE) begin
                    open_token(MODE_STRING, cursor + 32'd1, 8'h00);
                end else if (c == CHAR_EQUAL || c == CHAR_PLUS || c == CHAR_MINUS) begin
                    put_token(KIND_OPERATOR, cursor, 16'd1, c);
                end else begin
                    put_token(KIND_SYMBOL, cursor, 16'd1, c);
                end
            end
            cursor = cursor + 32'd1;
        end
        if (eos) begin
            close_token();
            put_token(KIND_EOF, cursor, 16'd0, 8'h00);
            clear_scanner();
        end
        if (batch.size() > 0) begin
            t = batch.pop_back();
            t.last = 1'b1;
            batch.push_back(t);
        end
        foreach (batch[i]) begin
            tokens_due.push_back(batch[i]);
        end
    endfunction

    function automatic void check_field(input string what, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act) begin
            if (fails < REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp, act);
            end
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            clear_scanner();
            tokens_due.delete();
        end else begin
            if (i_src.valid && i_src.ready) begin
                scan_source_byte(i_src.has_byte, i_src.data_byte, i_src.end_of_source);
            end
            if (i_tok.valid && i_tok.ready) begin
                if (tokens_due.size() == 0) begin
                    if (fails < REPORT_LIMIT) begin
                        $display("%0t: token with nothing pending, expected none, actual kind %0d",
                                 $time, i_tok.token_kind);
                        $display("%0t:   start %0h length %0h first %0h last %0b", $time,
                                 i_tok.token_start, i_tok.token_length, i_tok.first_char,
                                 i_tok.last_of_run);
                    end
                    fails++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", 32'(want.kind), 32'(i_tok.token_kind));
                    check_field("token_start", want.start, i_tok.token_start);
                    check_field("token_length", 32'(want.length), 32'(i_tok.token_length));
                    check_field("first_char", 32'(want.first), 32'(i_tok.first_char));
                    check_field("last_of_run", 32'(want.last), 32'(i_tok.last_of_run));
                end
            end
        end
        o_pending <= tokens_due.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ===== tb/sv/source_tokenizer_core_test.sv =====
// Testbench top for the source tokenizer: clock, reset, byte stimulus and the verdict.
`default_nettype none

module source_tokenizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import st_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 130;

    logic i_clk;
    logic i_rst_n;
    int   src_gap_pct;
    int   sink_stall_pct;
    int   items_sent;
    int   idle_cycles;
    int   fail_count;
    int   pending;

    string word_pool[16] = '{"class", "void", "int", "string", "clas", "classy", "voi",
                             "voids", "in", "int_", "strin", "strings", "i", "s", "c", "v"};
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    st_in_if  src_ch ();
    st_out_if tok_ch ();

    source_tokenizer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_ch),
        .o_out   (tok_ch)
    );

    token_stream_checker tok_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src        (src_ch),
        .i_tok        (tok_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        tok_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Ends the run if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic feed_source_byte(input logic has, input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < src_gap_pct) begin
            src_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_ch.valid <= 1'b1;
        src_ch.has_byte <= has;
        src_ch.data_byte <= b;
        src_ch.end_of_source <= eos;
        @(posedge i_clk);
        while (!src_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic feed_text(input string s, input logic eos_on_last);
        for (int i = 0; i < s.len(); i++) begin
            feed_source_byte(1'b1, s[i], eos_on_last && (i == s.len() - 1));
        end
    endtask

    // Holds the source back until every predicted token has been delivered.
    task automatic wait_for_drain();
        src_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] word_byte(input logic leading);
        if (leading) begin
            return word_chars[$urandom_range(52)];
        end
        return word_chars[$urandom_range(62)];
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CHAR_QUOTE);
        return b;
    endfunction

    // Any byte that stands alone as a one-byte symbol.
    function automatic logic [7:0] symbol_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9")
                   || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D) || b == CHAR_QUOTE
                   || b == CHAR_UNDERSCORE || b == CHAR_EQUAL || b == CHAR_PLUS
                   || b == CHAR_MINUS);
        return b;
    endfunction

    task automatic random_phase(input int goal);
        int stop_at;
        int pick;
        int len;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                feed_text(word_pool[$urandom_range(15)], 1'b0);
            end else if (pick < 35) begin
                feed_source_byte(1'b1, word_byte(1'b1), 1'b0);
                repeat ($urandom_range(7)) feed_source_byte(1'b1, word_byte(1'b0), 1'b0);
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 6)) begin
                    feed_source_byte(1'b1, 8'($urandom_range("0", "9")), 1'b0);
                end
            end else if (pick < 62) begin
                len = $urandom_range(6);
                feed_source_byte(1'b1, CHAR_QUOTE, 1'b0);
                repeat (len) feed_source_byte(1'b1, string_byte(), 1'b0);
                if ($urandom_range(9) == 0) begin
                    feed_source_byte(1'b0, 8'($urandom_range(255)), 1'b1);
                end else begin
                    feed_source_byte(1'b1, CHAR_QUOTE, 1'b0);
                end
            end else if (pick < 72) begin
                case ($urandom_range(2))
                    0: feed_source_byte(1'b1, CHAR_EQUAL, 1'b0);
                    1: feed_source_byte(1'b1, CHAR_PLUS, 1'b0);
                    default: feed_source_byte(1'b1, CHAR_MINUS, 1'b0);
                endcase
            end else if (pick < 80) begin
                feed_source_byte(1'b1, symbol_byte(), 1'b0);
            end else if (pick < 88) begin
                feed_source_byte(1'b1, 8'($urandom_range(255)), 1'b0);
            end else if (pick < 92) begin
                feed_source_byte(1'b0, 8'($urandom_range(255)), 1'b0);
            end else begin
                feed_source_byte(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1);
            end
            repeat ($urandom_range(2)) feed_source_byte(1'b1, blank_byte(), 1'b0);
        end
        feed_source_byte(1'b0, 8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        src_ch.valid = 1'b0;
        src_ch.has_byte = 1'b0;
        src_ch.data_byte = 8'h00;
        src_ch.end_of_source = 1'b0;
        tok_ch.ready = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        src_gap_pct = 14;
        sink_stall_pct = 48;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        feed_text("\"\"", 1'b0);
        feed_text("=+-", 1'b0);
        feed_source_byte(1'b1, 8'h00, 1'b0);
        feed_source_byte(1'b1, 8'hFF, 1'b0);
        feed_source_byte(1'b1, 8'h09, 1'b0);
        feed_text("_9 7a", 1'b0);
        feed_source_byte(1'b0, 8'hA5, 1'b0);
        feed_source_byte(1'b1, 8'h0D, 1'b0);
        // The plus sign closes the type, becomes an operator and ends the source.
        feed_text("int+", 1'b1);
        feed_source_byte(1'b1, "5", 1'b0);
        feed_source_byte(1'b0, 8'h00, 1'b1);
        feed_source_byte(1'b1, CHAR_QUOTE, 1'b0);
        feed_source_byte(1'b1, "q", 1'b0);
        feed_source_byte(1'b1, 8'h80, 1'b1);
        wait_for_drain();

        random_phase(PHASE_ITEMS);
        wait_for_drain();

        src_gap_pct = 48;
        sink_stall_pct <= 14;
        random_phase(PHASE_ITEMS);
        wait_for_drain();

        src_gap_pct = 0;
        sink_stall_pct <= 0;
        random_phase(PHASE_ITEMS);
        wait_for_drain();
        repeat (12) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
